// ===== hdl/thkr_pkg.sv =====
// Shared types, constants and key tables for the tap-hold key resolver.
// Used by the controller, the datapath and the top level; depends on nothing.

package thkr_pkg;

   localparam logic [15:0] EV_SYN         = 16'd0;
   localparam logic [15:0] EV_KEY         = 16'd1;
   localparam logic [15:0] SYNC_REPORT    = 16'd0;
   localparam logic [15:0] KEY_D          = 16'd32;
   localparam logic [15:0] KEY_F          = 16'd33;
   localparam logic [15:0] META_CODE      = 16'd125;
   localparam logic [15:0] LAYER_MARK     = 16'd256;
   localparam logic [15:0] DEFAULT_TIMEOUT = 16'd200;

   typedef enum logic [1:0] {
      QR_NONE,
      QR_HEAD,
      QR_SCAN,
      QR_TAIL
   } q_rd_type;

   typedef enum logic [2:0] {
      EM_ENTRY,
      EM_TBL,
      EM_MAP,
      EM_META,
      EM_SYNC
   } emit_kind_type;

   typedef enum logic [2:0] {
      RT_ZERO,
      RT_MAP,
      RT_SELF,
      RT_MARK,
      RT_META
   } rt_kind_type;

   typedef struct packed {
      logic          enq;
      q_rd_type      q_rd;
      logic          ld_entry;
      logic          scan_init;
      logic          scan_step;
      logic          pop;
      logic          drop_tail;
      logic          emit;
      emit_kind_type emit_kind;
      logic          rt_wr;
      rt_kind_type   rt_kind;
      logic          layer_set;
      logic          layer_clr;
      logic          flush;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic pend_valid;
      logic out_free;
      logic e_is_key;
      logic e_is_sync;
      logic e_val0;
      logic e_val1;
      logic e_val2;
      logic e_code_in;
      logic e_is_fd;
      logic e_is_f;
      logic m_is_mark;
      logic m_is_zero;
      logic m_is_mod;
      logic timeout;
      logic scan_end;
      logic scan_tap;
      logic scan_other;
   } status_type;

   // Alternate layer map: identity except for the layer overrides.
   function automatic logic [15:0] layer_map(input logic [15:0] code);
      logic [15:0] m;
      unique case (code)
         16'd35: m = 16'd105;
         16'd36: m = 16'd108;
         16'd37: m = 16'd103;
         16'd38: m = 16'd106;
         16'd22: m = 16'd179;
         16'd23: m = 16'd180;
         16'd24: m = 16'd26;
         16'd25: m = 16'd27;
         16'd49: m = 16'd41;
         16'd50: m = 16'd12;
         16'd51: m = 16'd13;
         16'd2:  m = 16'd59;
         16'd3:  m = 16'd60;
         16'd4:  m = 16'd61;
         16'd5:  m = 16'd62;
         16'd6:  m = 16'd63;
         16'd7:  m = 16'd64;
         16'd8:  m = 16'd65;
         16'd9:  m = 16'd66;
         16'd10: m = 16'd67;
         16'd11: m = 16'd68;
         16'd12: m = 16'd87;
         16'd43: m = 16'd88;
         default: m = code;
      endcase
      return m;
   endfunction

   function automatic logic is_modifier(input logic [15:0] c);
      return (c == 16'd56) || (c == 16'd100) || (c == 16'd29) || (c == 16'd97) ||
             (c == 16'd125) || (c == 16'd126) || (c == 16'd42) || (c == 16'd54);
   endfunction

endpackage

// ===== hdl/thkr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module thkr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/thkr_ctrl.sv =====
// Controller state machine for the tap-hold key resolver.
// Depends on thkr_pkg; drives commands to thkr_dp and reads its status.

module thkr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  thkr_pkg::status_type sts,
   output thkr_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RES,
      ST_LD,
      ST_DEC,
      ST_TMO,
      ST_SCAN_RD,
      ST_SCAN_CK,
      ST_TAP,
      ST_HOLD,
      ST_ER_RD,
      ST_ER_LD,
      ST_ER_DEC,
      ST_ER_SYNC,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff;
   logic      want_emit;
   logic      can_emit;

   assign can_emit = !sts.pend_valid || sts.out_free;

   always_comb begin
      cmd       = '0;
      want_emit = 1'b0;
      state_in  = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.enq  = 1'b1;
               state_in = ST_RES;
            end
         end
         ST_RES: begin
            if (sts.count_zero) begin
               state_in = ST_FIN;
            end else begin
               cmd.q_rd = thkr_pkg::QR_HEAD;
               state_in = ST_LD;
            end
         end
         ST_LD: begin
            cmd.ld_entry = 1'b1;
            state_in     = ST_DEC;
         end
         ST_DEC: begin
            state_in = ST_RES;
            cmd.pop  = 1'b1;
            if (!sts.e_is_key) begin
               if (sts.e_is_sync) begin
                  want_emit     = 1'b1;
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = thkr_pkg::EM_ENTRY;
               end
            end else if (sts.e_val0) begin
               if (sts.e_code_in) begin
                  cmd.rt_wr   = 1'b1;
                  cmd.rt_kind = thkr_pkg::RT_ZERO;
                  if (sts.m_is_mark) begin
                     cmd.layer_clr = 1'b1;
                  end else if (!sts.m_is_zero) begin
                     want_emit     = 1'b1;
                     cmd.emit      = 1'b1;
                     cmd.emit_kind = thkr_pkg::EM_TBL;
                  end
               end else begin
                  want_emit     = 1'b1;
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = thkr_pkg::EM_ENTRY;
               end
            end else if (sts.e_val1) begin
               if (sts.e_is_fd) begin
                  cmd.pop  = 1'b0;
                  state_in = ST_TMO;
               end else begin
                  want_emit     = 1'b1;
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = thkr_pkg::EM_MAP;
                  cmd.rt_wr     = sts.e_code_in;
                  cmd.rt_kind   = thkr_pkg::RT_MAP;
               end
            end else if (sts.e_val2) begin
               if (!sts.e_code_in) begin
                  want_emit     = 1'b1;
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = thkr_pkg::EM_ENTRY;
               end else if (!sts.m_is_mark) begin
                  want_emit     = 1'b1;
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = thkr_pkg::EM_TBL;
               end
            end
         end
         ST_TMO: begin
            if (sts.timeout) begin
               state_in = ST_HOLD;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            if (sts.scan_end) begin
               state_in = ST_ER_RD;
            end else begin
               cmd.q_rd = thkr_pkg::QR_SCAN;
               state_in = ST_SCAN_CK;
            end
         end
         ST_SCAN_CK: begin
            if (sts.scan_tap) begin
               state_in = ST_TAP;
            end else if (sts.scan_other) begin
               state_in = ST_HOLD;
            end else begin
               cmd.scan_step = 1'b1;
               state_in      = ST_SCAN_RD;
            end
         end
         ST_TAP: begin
            want_emit     = 1'b1;
            cmd.emit      = 1'b1;
            cmd.emit_kind = thkr_pkg::EM_ENTRY;
            cmd.rt_wr     = 1'b1;
            cmd.rt_kind   = thkr_pkg::RT_SELF;
            cmd.pop       = 1'b1;
            state_in      = ST_RES;
         end
         ST_HOLD: begin
            cmd.rt_wr = 1'b1;
            cmd.pop   = 1'b1;
            state_in  = ST_RES;
            if (sts.e_is_f) begin
               cmd.layer_set = 1'b1;
               cmd.rt_kind   = thkr_pkg::RT_MARK;
            end else begin
               want_emit     = 1'b1;
               cmd.emit      = 1'b1;
               cmd.emit_kind = thkr_pkg::EM_META;
               cmd.rt_kind   = thkr_pkg::RT_META;
            end
         end
         ST_ER_RD: begin
            cmd.q_rd = thkr_pkg::QR_TAIL;
            state_in = ST_ER_LD;
         end
         ST_ER_LD: begin
            cmd.ld_entry = 1'b1;
            state_in     = ST_ER_DEC;
         end
         ST_ER_DEC: begin
            state_in = ST_FIN;
            if (sts.e_is_key && sts.e_val0) begin
               if (sts.e_code_in && sts.m_is_mark) begin
                  cmd.layer_clr = 1'b1;
                  cmd.drop_tail = 1'b1;
               end else if (!sts.m_is_mod) begin
                  want_emit     = 1'b1;
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = sts.e_code_in ? thkr_pkg::EM_TBL : thkr_pkg::EM_ENTRY;
                  state_in      = ST_ER_SYNC;
               end
            end
         end
         ST_ER_SYNC: begin
            want_emit     = 1'b1;
            cmd.emit      = 1'b1;
            cmd.emit_kind = thkr_pkg::EM_SYNC;
            cmd.drop_tail = 1'b1;
            state_in      = ST_FIN;
         end
         ST_FIN: begin
            if (!sts.pend_valid) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // A result cannot be taken yet: hold every side effect and retry.
      if (want_emit && !can_emit) begin
         cmd      = '0;
         state_in = state_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stall_ff <= (state_in != ST_IDLE);
      end
   end

   assign req_stall = stall_ff;

endmodule

// ===== hdl/thkr_dp.sv =====
// Datapath of the tap-hold key resolver: event queue, release table, scan
// state, timing and the result registers. Depends on thkr_pkg and thkr_ram.

module thkr_dp #(
   parameter int QUEUE_DEPTH = 32,
   parameter int CODE_COUNT  = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  thkr_pkg::cmd_type    cmd,
   output thkr_pkg::status_type sts,
   input  logic                 csr_wr_en,
   input  logic [15:0]          csr_wr_data,
   input  logic                 req_command,
   input  logic [15:0]          req_event_type,
   input  logic [15:0]          req_key_code,
   input  logic signed [31:0]   req_key_value,
   input  logic [31:0]          req_time_ms,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [15:0]          rsp_out_type,
   output logic [15:0]          rsp_out_code,
   output logic signed [31:0]   rsp_out_value,
   output logic [31:0]          rsp_out_time_ms,
   output logic                 rsp_last
);

   localparam int QW  = $clog2(QUEUE_DEPTH);
   localparam int CW  = $clog2(CODE_COUNT);
   localparam int RTW = CW + 1;
   localparam logic [QW+1:0] DEPTH_W = (QW + 2)'(QUEUE_DEPTH);
   localparam logic [15:0]   CODES_W = 16'(CODE_COUNT);

   function automatic logic [QW-1:0] wrap(input logic [QW+1:0] s);
      logic [QW+1:0] r;
      r = (s >= DEPTH_W) ? (s - DEPTH_W) : s;
      return r[QW-1:0];
   endfunction

   logic [15:0]        tmo_ff;
   logic [31:0]        cur_time_ff;
   logic [QW-1:0]      head_ff;
   logic [QW:0]        count_ff;
   logic [QW:0]        idx_ff;
   logic               layer_ff;
   logic [CODE_COUNT-1:0] seen_ff;
   logic [CODE_COUNT-1:0] rt_vld_ff;
   logic               rt_vld_rd_ff;

   logic [15:0]        e_type_ff;
   logic [15:0]        e_code_ff;
   logic signed [31:0] e_value_ff;
   logic [31:0]        e_time_ff;

   logic               pend_v_ff;
   logic [15:0]        pend_type_ff;
   logic [15:0]        pend_code_ff;
   logic signed [31:0] pend_value_ff;
   logic [31:0]        pend_time_ff;

   logic               out_v_ff;
   logic [15:0]        out_type_ff;
   logic [15:0]        out_code_ff;
   logic signed [31:0] out_value_ff;
   logic [31:0]        out_time_ff;
   logic               out_last_ff;

   logic               q_we;
   logic [QW-1:0]      q_waddr;
   logic [QW-1:0]      q_raddr;
   logic [95:0]        q_rdata;
   logic [RTW-1:0]     rt_rdata;
   logic [RTW-1:0]     rt_wdata;
   logic [RTW-1:0]     rt_val;
   logic [15:0]        rt_val16;
   logic [15:0]        mapped;
   logic [31:0]        age;
   logic               out_free;

   logic [15:0]        sq_type;
   logic [15:0]        sq_code;
   logic signed [31:0] sq_value;
   logic               sq_in;

   logic [15:0]        em_type;
   logic [15:0]        em_code;
   logic signed [31:0] em_value;
   logic [31:0]        em_time;

   assign q_we    = cmd.enq && !req_command && (count_ff < DEPTH_W[QW:0]);
   assign q_waddr = wrap({2'b00, head_ff} + {1'b0, count_ff});

   always_comb begin
      unique case (cmd.q_rd)
         thkr_pkg::QR_SCAN: q_raddr = wrap({2'b00, head_ff} + {1'b0, idx_ff});
         thkr_pkg::QR_TAIL: q_raddr = wrap({2'b00, head_ff} + {1'b0, count_ff} - 1'b1);
         default:           q_raddr = head_ff;
      endcase
   end

   thkr_ram #(
      .WIDTH(96),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .we   (q_we),
      .waddr(q_waddr),
      .wdata({req_event_type, req_key_code, req_key_value, req_time_ms}),
      .re   (cmd.q_rd != thkr_pkg::QR_NONE),
      .raddr(q_raddr),
      .rdata(q_rdata)
   );

   thkr_ram #(
      .WIDTH(RTW),
      .DEPTH(CODE_COUNT)
   ) u_release (
      .clock(clock),
      .we   (cmd.rt_wr),
      .waddr(e_code_ff[CW-1:0]),
      .wdata(rt_wdata),
      .re   (cmd.ld_entry),
      .raddr(q_rdata[64 +: CW]),
      .rdata(rt_rdata)
   );

   // Entries never written since reset read as zero.
   assign rt_val   = rt_vld_rd_ff ? rt_rdata : '0;
   assign rt_val16 = 16'(rt_val);
   assign mapped   = (e_code_ff < CODES_W && layer_ff) ?
                     thkr_pkg::layer_map(e_code_ff) : e_code_ff;

   always_comb begin
      unique case (cmd.rt_kind)
         thkr_pkg::RT_MAP:  rt_wdata = RTW'(mapped);
         thkr_pkg::RT_SELF: rt_wdata = RTW'(e_code_ff);
         thkr_pkg::RT_MARK: rt_wdata = RTW'(thkr_pkg::LAYER_MARK);
         thkr_pkg::RT_META: rt_wdata = RTW'(thkr_pkg::META_CODE);
         default:           rt_wdata = '0;
      endcase
   end

   always_comb begin
      em_type  = e_type_ff;
      em_code  = e_code_ff;
      em_value = e_value_ff;
      em_time  = e_time_ff;
      unique case (cmd.emit_kind)
         thkr_pkg::EM_TBL:  em_code = rt_val16;
         thkr_pkg::EM_MAP:  em_code = mapped;
         thkr_pkg::EM_META: em_code = thkr_pkg::META_CODE;
         thkr_pkg::EM_SYNC: begin
            em_type  = thkr_pkg::EV_SYN;
            em_code  = thkr_pkg::SYNC_REPORT;
            em_value = '0;
         end
         default: em_code = e_code_ff;
      endcase
   end

   assign sq_type  = q_rdata[95:80];
   assign sq_code  = q_rdata[79:64];
   assign sq_value = q_rdata[63:32];
   assign sq_in    = sq_code < CODES_W;
   assign age      = cur_time_ff - e_time_ff;
   assign out_free = !out_v_ff || !rsp_stall;

   always_comb begin
      sts            = '0;
      sts.count_zero = (count_ff == '0);
      sts.pend_valid = pend_v_ff;
      sts.out_free   = out_free;
      sts.e_is_key   = (e_type_ff == thkr_pkg::EV_KEY);
      sts.e_is_sync  = (e_type_ff == thkr_pkg::EV_SYN);
      sts.e_val0     = (e_value_ff == 32'sd0);
      sts.e_val1     = (e_value_ff == 32'sd1);
      sts.e_val2     = (e_value_ff == 32'sd2);
      sts.e_code_in  = (e_code_ff < CODES_W);
      sts.e_is_f     = (e_code_ff == thkr_pkg::KEY_F);
      sts.e_is_fd    = sts.e_is_f || (e_code_ff == thkr_pkg::KEY_D);
      sts.m_is_mark  = (rt_val16 == thkr_pkg::LAYER_MARK);
      sts.m_is_zero  = (rt_val == '0);
      sts.m_is_mod   = thkr_pkg::is_modifier(sts.e_code_in ? rt_val16 : e_code_ff);
      sts.timeout    = !age[31] && (age > {16'd0, tmo_ff});
      sts.scan_end   = (idx_ff >= count_ff);
      sts.scan_tap   = (sq_type == thkr_pkg::EV_KEY) && (sq_value == 32'sd0) &&
                       (sq_code == e_code_ff);
      sts.scan_other = (sq_type == thkr_pkg::EV_KEY) && (sq_value == 32'sd0) &&
                       sq_in && seen_ff[sq_code[CW-1:0]];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         tmo_ff       <= thkr_pkg::DEFAULT_TIMEOUT;
         cur_time_ff  <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         layer_ff     <= 1'b0;
         rt_vld_ff    <= '0;
         rt_vld_rd_ff <= 1'b0;
         pend_v_ff    <= 1'b0;
         out_v_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            tmo_ff <= csr_wr_data;
         end
         if (cmd.enq) begin
            cur_time_ff <= req_time_ms;
         end
         if (q_we) begin
            count_ff <= count_ff + 1'b1;
         end else if (cmd.pop) begin
            head_ff  <= wrap({2'b00, head_ff} + 1'b1);
            count_ff <= count_ff - 1'b1;
         end else if (cmd.drop_tail) begin
            count_ff <= count_ff - 1'b1;
         end
         if (cmd.scan_init) begin
            idx_ff <= (QW + 1)'(1);
         end else if (cmd.scan_step) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.layer_set) begin
            layer_ff <= 1'b1;
         end else if (cmd.layer_clr) begin
            layer_ff <= 1'b0;
         end
         if (cmd.rt_wr) begin
            rt_vld_ff[e_code_ff[CW-1:0]] <= 1'b1;
         end
         if (cmd.ld_entry) begin
            rt_vld_rd_ff <= rt_vld_ff[q_rdata[64 +: CW]];
         end
         if (cmd.emit) begin
            pend_v_ff <= 1'b1;
         end else if (cmd.flush) begin
            pend_v_ff <= 1'b0;
         end
         if ((cmd.emit && pend_v_ff) || cmd.flush) begin
            out_v_ff <= 1'b1;
         end else if (out_v_ff && !rsp_stall) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         seen_ff <= '0;
      end else if (cmd.scan_step && (sq_type == thkr_pkg::EV_KEY) &&
                   (sq_value == 32'sd1) && sq_in) begin
         seen_ff[sq_code[CW-1:0]] <= 1'b1;
      end
      if (cmd.ld_entry) begin
         e_type_ff  <= sq_type;
         e_code_ff  <= sq_code;
         e_value_ff <= sq_value;
         e_time_ff  <= q_rdata[31:0];
      end
      if (cmd.emit) begin
         pend_type_ff  <= em_type;
         pend_code_ff  <= em_code;
         pend_value_ff <= em_value;
         pend_time_ff  <= em_time;
      end
      // The held result moves out once the next one exists, or at the end.
      if ((cmd.emit && pend_v_ff) || cmd.flush) begin
         out_type_ff  <= pend_type_ff;
         out_code_ff  <= pend_code_ff;
         out_value_ff <= pend_value_ff;
         out_time_ff  <= pend_time_ff;
         out_last_ff  <= cmd.flush;
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_out_type    = out_type_ff;
   assign rsp_out_code    = out_code_ff;
   assign rsp_out_value   = out_value_ff;
   assign rsp_out_time_ms = out_time_ff;
   assign rsp_last        = out_last_ff;

endmodule

// ===== hdl/tap_hold_key_resolver.sv =====
// Tap-hold key resolver: one item at a time. Each item is transferred, its queued
// events are resolved in order and the pass finishes; an F or D press that has
// not timed out also scans the later queued events for tap or hold, and an early
// release adds a read of the queue tail. The event queue memory has a single read
// port. Stalls on the result channel hold the pass. Results leave through an
// output register, and the last result of an item carries rsp_last. Depends on
// thkr_pkg, thkr_ctrl and thkr_dp.

module tap_hold_key_resolver #(
   parameter int QUEUE_DEPTH = 32,
   parameter int CODE_COUNT  = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic [15:0]        req_event_type,
   input  logic [15:0]        req_key_code,
   input  logic signed [31:0] req_key_value,
   input  logic [31:0]        req_time_ms,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_out_type,
   output logic [15:0]        rsp_out_code,
   output logic signed [31:0] rsp_out_value,
   output logic [31:0]        rsp_out_time_ms,
   output logic               rsp_last
);

   thkr_pkg::cmd_type    cmd;
   thkr_pkg::status_type sts;

   thkr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .sts      (sts),
      .cmd      (cmd)
   );

   thkr_dp #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .CODE_COUNT (CODE_COUNT)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_command    (req_command),
      .req_event_type (req_event_type),
      .req_key_code   (req_key_code),
      .req_key_value  (req_key_value),
      .req_time_ms    (req_time_ms),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_type   (rsp_out_type),
      .rsp_out_code   (rsp_out_code),
      .rsp_out_value  (rsp_out_value),
      .rsp_out_time_ms(rsp_out_time_ms),
      .rsp_last       (rsp_last)
   );

`ifndef SYNTHESIS
   // While the block is open for a new item, no result is held back.
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !sts.pend_valid)
      else $error("result still held while accepting a new item");

   // Every accepted item starts a resolve pass.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block did not start work after a transfer");
`endif

endmodule

// ===== tb/thkr_checker.sv =====
// Checker for the tap-hold key resolver: watches the register port and both channels,
// predicts every emitted event and compares it field by field. Depends on thkr_pkg.

module thkr_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_command,
   input  logic [15:0]        req_event_type,
   input  logic [15:0]        req_key_code,
   input  logic signed [31:0] req_key_value,
   input  logic [31:0]        req_time_ms,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [15:0]        rsp_out_type,
   input  logic [15:0]        rsp_out_code,
   input  logic signed [31:0] rsp_out_value,
   input  logic [31:0]        rsp_out_time_ms,
   input  logic               rsp_last,
   output int                 fail_count,
   output int                 pending_events
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 32;
   localparam int CODES = 256;

   typedef enum logic [1:0] {HOLD_TIMEOUT, HOLD_TAP, HOLD_OTHER, HOLD_NONE} hold_verdict_type;

   typedef struct {
      logic [15:0] etype;
      logic [15:0] code;
      logic [31:0] value;
      logic [31:0] stamp;
      logic        last;
   } out_event_type;

   out_event_type expected_events[$];

   logic [15:0] ring_type [DEPTH];
   logic [15:0] ring_code [DEPTH];
   logic [31:0] ring_value[DEPTH];
   logic [31:0] ring_stamp[DEPTH];
   int          ring_head, ring_count;
   logic [15:0] send_on_release[CODES];
   logic [15:0] alt_layer [CODES];
   bit          alt_on;
   logic [31:0] now_ms;
   logic [15:0] hold_ms;

   function automatic bit modifier_code(logic [15:0] c);
      return c inside {16'd56, 16'd100, 16'd29, 16'd97, 16'd125, 16'd126, 16'd42, 16'd54};
   endfunction

   function automatic void restart_model();
      for (int i = 0; i < CODES; i++) begin
         send_on_release[i] = '0;
         alt_layer[i]       = 16'(i);
      end
      alt_layer[35] = 16'd105; alt_layer[36] = 16'd108;
      alt_layer[37] = 16'd103; alt_layer[38] = 16'd106;
      alt_layer[22] = 16'd179; alt_layer[23] = 16'd180;
      alt_layer[24] = 16'd26;  alt_layer[25] = 16'd27;
      alt_layer[49] = 16'd41;  alt_layer[50] = 16'd12;  alt_layer[51] = 16'd13;
      for (int i = 2; i <= 11; i++) alt_layer[i] = 16'(57 + i);
      alt_layer[12] = 16'd87;  alt_layer[43] = 16'd88;
      ring_head = 0;
      ring_count = 0;
      alt_on = 0;
      now_ms = '0;
      hold_ms = thkr_pkg::DEFAULT_TIMEOUT;
   endfunction

   function automatic void push_event(logic [15:0] t, logic [15:0] c, logic [31:0] v,
                                      logic [31:0] s);
      out_event_type ev;
      ev.etype = t; ev.code = c; ev.value = v; ev.stamp = s; ev.last = 1'b0;
      expected_events.push_back(ev);
   endfunction

   function automatic hold_verdict_type judge_hold(logic [15:0] code, logic [31:0] stamp);
      logic [31:0] age;
      bit          pressed[CODES];
      int          k;
      age = now_ms - stamp;
      if (!age[31] && age > {16'd0, hold_ms}) return HOLD_TIMEOUT;
      for (int i = 0; i < CODES; i++) pressed[i] = 0;
      for (int i = 1; i < ring_count; i++) begin
         k = (ring_head + i) % DEPTH;
         if (ring_type[k] != thkr_pkg::EV_KEY) continue;
         if (ring_value[k] == 0 && ring_code[k] == code) return HOLD_TAP;
         else if (ring_value[k] == 1 && ring_code[k] < CODES) pressed[ring_code[k]] = 1;
         else if (ring_value[k] == 0 && ring_code[k] < CODES && pressed[ring_code[k]])
            return HOLD_OTHER;
      end
      return HOLD_NONE;
   endfunction

   // Returns 1 when the oldest event was consumed and resolution should continue.
   function automatic bit resolve_head();
      logic [15:0] t, c, m;
      logic [31:0] v, s;
      hold_verdict_type w;
      int          k;
      if (ring_count == 0) return 0;
      t = ring_type[ring_head]; c = ring_code[ring_head];
      v = ring_value[ring_head]; s = ring_stamp[ring_head];
      if (t == thkr_pkg::EV_KEY && v == 1 && (c == thkr_pkg::KEY_F || c == thkr_pkg::KEY_D))
      begin
         w = judge_hold(c, s);
         if (w == HOLD_TAP) begin
            push_event(t, c, v, s);
            send_on_release[c] = c;
         end else if (w != HOLD_NONE) begin
            if (c == thkr_pkg::KEY_F) begin
               alt_on = 1;
               send_on_release[thkr_pkg::KEY_F] = thkr_pkg::LAYER_MARK;
            end else begin
               send_on_release[thkr_pkg::KEY_D] = thkr_pkg::META_CODE;
               push_event(t, thkr_pkg::META_CODE, v, s);
            end
         end else begin
            // The pending press stays; a newer release may still go out early.
            k = (ring_head + ring_count - 1) % DEPTH;
            if (ring_type[k] != thkr_pkg::EV_KEY || ring_value[k] != 0) return 0;
            m = ring_code[k];
            if (m < CODES) begin
               m = send_on_release[m];
               if (m == thkr_pkg::LAYER_MARK) begin
                  alt_on = 0;
                  ring_count--;
                  return 0;
               end
            end
            if (modifier_code(m)) return 0;
            push_event(ring_type[k], m, ring_value[k], ring_stamp[k]);
            push_event(thkr_pkg::EV_SYN, thkr_pkg::SYNC_REPORT, '0, ring_stamp[k]);
            ring_count--;
            return 0;
         end
      end else if (t == thkr_pkg::EV_KEY && v == 1) begin
         m = c;
         if (c < CODES) begin
            if (alt_on) m = alt_layer[c];
            send_on_release[c] = m;
         end
         push_event(t, m, v, s);
      end else if (t == thkr_pkg::EV_KEY && v == 0) begin
         if (c < CODES) begin
            m = send_on_release[c];
            send_on_release[c] = '0;
            if (m == thkr_pkg::LAYER_MARK) alt_on = 0;
            else if (m != 0) push_event(t, m, v, s);
         end else begin
            push_event(t, c, v, s);
         end
      end else if (t == thkr_pkg::EV_KEY && v == 2) begin
         if (c >= CODES) push_event(t, c, v, s);
         else if (send_on_release[c] != thkr_pkg::LAYER_MARK)
            push_event(t, send_on_release[c], v, s);
      end else if (t == thkr_pkg::EV_SYN) begin
         push_event(t, c, v, s);
      end
      ring_head = (ring_head + 1) % DEPTH;
      ring_count--;
      return 1;
   endfunction

   function automatic void predict_transfer();
      int n_prior, k;
      n_prior = expected_events.size();
      now_ms = req_time_ms;
      if (!req_command && ring_count < DEPTH) begin
         k = (ring_head + ring_count) % DEPTH;
         ring_type[k] = req_event_type; ring_code[k] = req_key_code;
         ring_value[k] = req_key_value; ring_stamp[k] = req_time_ms;
         ring_count++;
      end
      while (resolve_head()) ;
      if (expected_events.size() > n_prior)
         expected_events[expected_events.size() - 1].last = 1'b1;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      pending_events = 0;
      restart_model();
   end

   always @(posedge clock) begin
      out_event_type ev;
      if (reset) begin
         restart_model();
         expected_events.delete();
      end else begin
         if (csr_wr_en) hold_ms = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               $error("unexpected result: type %0h code %0h", rsp_out_type, rsp_out_code);
               fail_count++;
            end else begin
               ev = expected_events.pop_front();
               check_field("out_type", ev.etype, rsp_out_type);
               check_field("out_code", ev.code, rsp_out_code);
               check_field("out_value", ev.value, rsp_out_value);
               check_field("out_time_ms", ev.stamp, rsp_out_time_ms);
               check_field("last", 32'(ev.last), 32'(rsp_last));
            end
         end
         if (req_valid && !req_stall) predict_transfer();
      end
      pending_events = expected_events.size();
   end

endmodule

// ===== tb/tb.sv =====
// Top of the tap-hold key resolver testbench: clock, reset, stimulus and verdict.
// Depends on thkr_pkg, the resolver RTL and thkr_checker.

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT  = 20000;
   localparam int SETTLE_WAIT = 400;

   logic               clock = 0;
   logic               reset = 1;
   logic               csr_wr_en = 0;
   logic [15:0]        csr_wr_data = '0;
   logic               req_valid = 0;
   logic               req_stall;
   logic               req_command = 0;
   logic [15:0]        req_event_type = '0;
   logic [15:0]        req_key_code = '0;
   logic signed [31:0] req_key_value = '0;
   logic [31:0]        req_time_ms = '0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic [15:0]        rsp_out_type;
   logic [15:0]        rsp_out_code;
   logic signed [31:0] rsp_out_value;
   logic [31:0]        rsp_out_time_ms;
   logic               rsp_last;
   int                 fail_count, pending_events;
   int                 idle_cycles = 0;
   int                 stall_left = 0;
   int                 checker_items = 0;
   bit                 quiet = 0;
   logic [31:0]        clock_ms = 0;
   logic [15:0]        hold_setting = thkr_pkg::DEFAULT_TIMEOUT;

   tap_hold_key_resolver dut (.*);
   thkr_checker u_checker (.*);

   always #5 clock = ~clock;

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1;
         stall_left--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1;
         stall_left = $urandom_range(0, 4);
      end else begin
         rsp_stall <= 0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   always @(posedge clock) if (req_valid && !req_stall) checker_items <= checker_items + 1;

   // Valid stays high after a transfer; it drops only for idling or before waiting.
   task automatic send_event(logic cmd, logic [15:0] etype, logic [15:0] code,
                             logic [31:0] value, logic [31:0] stamp);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid      <= 1;
      req_command    <= cmd;
      req_event_type <= etype;
      req_key_code   <= code;
      req_key_value  <= value;
      req_time_ms    <= stamp;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic key(logic [15:0] code, logic [31:0] value);
      clock_ms += $urandom_range(0, 40);
      send_event(1'b0, thkr_pkg::EV_KEY, code, value, clock_ms);
   endtask

   task automatic tick(logic [31:0] step);
      clock_ms += step;
      send_event(1'b1, 16'($urandom), 16'($urandom), $urandom, clock_ms);
   endtask

   task automatic wait_quiet();
      req_valid <= 0;
      while (pending_events != 0 || req_stall) @(negedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);
   endtask

   task automatic write_timeout(logic [15:0] value);
      wait_quiet();
      csr_wr_en   <= 1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 0;
      hold_setting = value;
   endtask

   function automatic logic [15:0] pick_code();
      case ($urandom_range(0, 9))
         0, 1:    return $urandom_range(0, 1) ? thkr_pkg::KEY_F : thkr_pkg::KEY_D;
         2, 3:    return 16'($urandom_range(2, 12));
         4:       return 16'($urandom_range(22, 25));
         5:       return 16'($urandom_range(35, 38));
         6:       return $urandom_range(0, 1) ? 16'd42 : 16'd125;
         7:       return 16'($urandom_range(0, 255));
         8:       return 16'($urandom_range(256, 65535));
         default: return 16'($urandom_range(44, 51));
      endcase
   endfunction

   // One burst of mostly well-formed keyboard activity.
   task automatic random_phrase();
      logic [15:0] hk, other;
      hk = $urandom_range(0, 1) ? thkr_pkg::KEY_F : thkr_pkg::KEY_D;
      other = pick_code();
      case ($urandom_range(0, 6))
         0: begin key(hk, 1); key(hk, 2); key(hk, 0); end
         1: begin key(hk, 1); key(other, 1); key(other, 0); key(other, 1); key(hk, 0);
                  key(other, 0); end
         2: begin key(hk, 1); tick(32'(hold_setting) + $urandom_range(1, 3)); key(other, 1);
                  key(other, 2); key(other, 0); key(hk, 0); end
         3: begin key(other, 1); key(other, 2); key(other, 0); end
         4: begin key(hk, 1); key(other, 0); key(pick_code(), 0); key(hk, 0); end
         5: send_event(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0 ? 16'($urandom)
                       : thkr_pkg::EV_SYN, 16'($urandom), $urandom,
                       $urandom_range(0, 1) ? $urandom : clock_ms);
         default: begin key(pick_code(), $urandom_range(0, 3)); tick($urandom_range(0, 300)); end
      endcase
   endtask

   task automatic random_phase(int count, logic [15:0] timeout);
      int start;
      write_timeout(timeout);
      start = checker_items;
      while (checker_items - start < count) random_phrase();
      // Release the F and D keys that the phrases may have left held.
      tick(32'(timeout) + 2);
      key(thkr_pkg::KEY_F, 0); key(thkr_pkg::KEY_D, 0);
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 0;
      // Directed part at the default timeout.
      send_event(1'b0, thkr_pkg::EV_SYN, thkr_pkg::SYNC_REPORT, 0, 0);
      key(16'd300, 1); key(16'hFFFF, 2); key(16'd300, 0);
      key(16'd30, 1); key(16'd30, 2); key(16'd30, 0);
      key(16'd30, 32'h8000_0000); key(16'd30, 32'h7FFF_FFFF);
      send_event(1'b0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, clock_ms);
      key(thkr_pkg::KEY_F, 1); key(thkr_pkg::KEY_F, 0);
      key(thkr_pkg::KEY_D, 1); key(thkr_pkg::KEY_D, 0);
      key(thkr_pkg::KEY_F, 1); key(16'd35, 1); key(16'd35, 0); key(16'd35, 1);
      key(thkr_pkg::KEY_F, 0);
      key(16'd35, 0);
      key(thkr_pkg::KEY_D, 1); tick(201); key(16'd20, 1); key(16'd20, 0);
      key(thkr_pkg::KEY_D, 0);
      key(thkr_pkg::KEY_F, 1); key(16'd30, 1); key(16'd30, 0); key(thkr_pkg::KEY_F, 0);
      // Overflow the ring behind a pending F press, then let it time out.
      key(thkr_pkg::KEY_F, 1);
      for (int i = 0; i < 34; i++) send_event(1'b0, thkr_pkg::EV_KEY, 16'd30, 1, clock_ms);
      tick(300); key(thkr_pkg::KEY_F, 0); key(16'd30, 0);
      send_event(1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      key(thkr_pkg::KEY_F, 1); tick(0);
      send_event(1'b1, 0, 0, 0, 0);
      clock_ms = 0;
      tick(500); key(thkr_pkg::KEY_F, 0);
      random_phase(35, 16'd1);
      random_phase(35, 16'd65535);
      random_phase(35, 16'($urandom_range(1, 400)));
      quiet = 1;
      random_phase(35, thkr_pkg::DEFAULT_TIMEOUT);
      wait_quiet();
      if (fail_count == 0 && pending_events == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/thkr_pkg.sv
hdl/thkr_ram.sv
hdl/thkr_ctrl.sv
hdl/thkr_dp.sv
hdl/tap_hold_key_resolver.sv
tb/thkr_checker.sv
tb/tb.sv
